>>> src/anbs_pkg.sv
// shared types, constants and helpers of the annex b nal unit splitter
package anbs_pkg;

	localparam int POSITION_BITS_DEFAULT = 24;
	localparam int COUNT_BITS_DEFAULT    = 16;

	localparam int OFFSET_W = 24;
	localparam int COUNT_W  = 16;
	localparam int TYPE_W   = 5;

	localparam int RESULT_SLOTS = 3;
	localparam int RQ_DEPTH     = 4;

	localparam int ADDR_BITS = 3;
	localparam logic [ADDR_BITS-3:0] REG_SLICE_HEADER_LIMIT = 1'b0;
	localparam logic [15:0] SLICE_HEADER_LIMIT_RESET = 16'd256;

	localparam logic [7:0] BYTE_ZERO  = 8'h00;
	localparam logic [7:0] BYTE_ONE   = 8'h01;
	localparam int         PREFIX_LEN = 3;

	localparam logic [TYPE_W-1:0] SLICE_TYPE_MIN = 5'd1;
	localparam logic [TYPE_W-1:0] SLICE_TYPE_MAX = 5'd5;
	localparam logic [TYPE_W-1:0] WHOLE_TYPE_MIN = 5'd6;
	localparam logic [TYPE_W-1:0] WHOLE_TYPE_MAX = 5'd8;

	localparam logic KIND_UNIT    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		ZP_NONE,
		ZP_ONE,
		ZP_MANY
	} zphase_t;

	typedef struct packed {
		logic                record_kind;
		logic [OFFSET_W-1:0] unit_offset;
		logic [OFFSET_W-1:0] unit_length;
		logic [OFFSET_W-1:0] header_length;
		logic [TYPE_W-1:0]   unit_type;
		logic [COUNT_W-1:0]  kept_count;
		logic                last_result;
	} result_t;

	function automatic logic is_slice(logic [TYPE_W-1:0] t);
		return (t >= SLICE_TYPE_MIN) && (t <= SLICE_TYPE_MAX);
	endfunction

	function automatic logic is_kept(logic [TYPE_W-1:0] t);
		return is_slice(t) || ((t >= WHOLE_TYPE_MIN) && (t <= WHOLE_TYPE_MAX));
	endfunction

	function automatic logic [OFFSET_W-1:0] to_offset_field(logic [31:0] v);
		return v[OFFSET_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] to_count_field(logic [31:0] v);
		return v[COUNT_W-1:0];
	endfunction

endpackage

>>> src/anbs_parse.sv
// start code scanner and unit bookkeeping, one byte per transfer
module anbs_parse #(
	parameter int POSITION_BITS = anbs_pkg::POSITION_BITS_DEFAULT,
	parameter int COUNT_BITS    = anbs_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                advance,
	input  logic [7:0]                                          data_byte,
	input  logic                                                end_of_buffer,
	input  logic [15:0]                                         slice_header_limit,
	output anbs_pkg::result_t [anbs_pkg::RESULT_SLOTS-1:0]      cand,
	output logic [anbs_pkg::RESULT_SLOTS-1:0]                   cand_valid
);

	localparam int LW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [COUNT_BITS-1:0]    CNT_MAX = '1;
	localparam logic [POSITION_BITS-1:0] PREFIX  = POSITION_BITS'(anbs_pkg::PREFIX_LEN);

	logic [POSITION_BITS-1:0]          byte_position_q;
	anbs_pkg::zphase_t                 zero_phase_q;
	logic                              start_pending_q;
	logic                              unit_open_q;
	logic [POSITION_BITS-1:0]          open_offset_q;
	logic [anbs_pkg::TYPE_W-1:0]       open_type_q;
	logic [COUNT_BITS-1:0]             kept_total_q;

	anbs_pkg::zphase_t                 zero_phase_d;
	logic                              start_pending_d;
	logic [POSITION_BITS-1:0]          pos_diff;
	logic [POSITION_BITS-1:0]          len1;
	logic [POSITION_BITS-1:0]          len2;
	logic [POSITION_BITS-1:0]          end_pos;
	logic [POSITION_BITS-1:0]          new_offset;
	logic [anbs_pkg::TYPE_W-1:0]       new_type;
	logic                              new_open;
	logic                              keep1;
	logic                              keep2;
	logic [COUNT_BITS-1:0]             kept_after1;
	logic [COUNT_BITS-1:0]             kept_after2;

	function automatic logic [anbs_pkg::OFFSET_W-1:0] header_len(
		logic [POSITION_BITS-1:0] len, logic [anbs_pkg::TYPE_W-1:0] t, logic [15:0] limit);
		logic [LW-1:0] l;
		logic [LW-1:0] lim;
		l   = LW'(len);
		lim = LW'(limit);
		if (anbs_pkg::is_slice(t) && (lim < l)) begin
			l = lim;
		end
		return anbs_pkg::to_offset_field(32'(l));
	endfunction

	always_comb begin
		zero_phase_d    = anbs_pkg::ZP_NONE;
		start_pending_d = 1'b0;
		if (start_pending_q) begin
			zero_phase_d = anbs_pkg::ZP_NONE;
		end else if (data_byte == anbs_pkg::BYTE_ZERO) begin
			case (zero_phase_q)
				anbs_pkg::ZP_NONE: zero_phase_d = anbs_pkg::ZP_ONE;
				anbs_pkg::ZP_ONE:  zero_phase_d = anbs_pkg::ZP_MANY;
				anbs_pkg::ZP_MANY: zero_phase_d = anbs_pkg::ZP_MANY;
				default:           zero_phase_d = anbs_pkg::ZP_NONE;
			endcase
		end else if (data_byte == anbs_pkg::BYTE_ONE && zero_phase_q == anbs_pkg::ZP_MANY) begin
			start_pending_d = 1'b1;
		end
	end

	always_comb begin
		pos_diff = byte_position_q - open_offset_q;
		len1 = ((byte_position_q >= open_offset_q) && (pos_diff >= PREFIX)) ?
			pos_diff - PREFIX : '0;
		keep1 = start_pending_q && unit_open_q && anbs_pkg::is_kept(open_type_q);

		new_offset = start_pending_q ? byte_position_q : open_offset_q;
		new_type   = start_pending_q ? data_byte[anbs_pkg::TYPE_W-1:0] : open_type_q;
		new_open   = start_pending_q || unit_open_q;
		end_pos    = (byte_position_q != POS_MAX) ? byte_position_q + 1'b1 : POS_MAX;
		len2       = (end_pos >= new_offset) ? end_pos - new_offset : '0;
		keep2      = end_of_buffer && new_open && anbs_pkg::is_kept(new_type);

		kept_after1 = (keep1 && kept_total_q != CNT_MAX) ? kept_total_q + 1'b1 : kept_total_q;
		kept_after2 = (keep2 && kept_after1 != CNT_MAX) ? kept_after1 + 1'b1 : kept_after1;
	end

	always_comb begin
		cand[0].record_kind   = anbs_pkg::KIND_UNIT;
		cand[0].unit_offset   = anbs_pkg::to_offset_field(32'(open_offset_q));
		cand[0].unit_length   = anbs_pkg::to_offset_field(32'(len1));
		cand[0].header_length = header_len(len1, open_type_q, slice_header_limit);
		cand[0].unit_type     = open_type_q;
		cand[0].kept_count    = '0;
		cand[0].last_result   = !end_of_buffer;

		cand[1].record_kind   = anbs_pkg::KIND_UNIT;
		cand[1].unit_offset   = anbs_pkg::to_offset_field(32'(new_offset));
		cand[1].unit_length   = anbs_pkg::to_offset_field(32'(len2));
		cand[1].header_length = header_len(len2, new_type, slice_header_limit);
		cand[1].unit_type     = new_type;
		cand[1].kept_count    = '0;
		cand[1].last_result   = 1'b0;

		cand[2].record_kind   = anbs_pkg::KIND_SUMMARY;
		cand[2].unit_offset   = '0;
		cand[2].unit_length   = '0;
		cand[2].header_length = '0;
		cand[2].unit_type     = '0;
		cand[2].kept_count    = anbs_pkg::to_count_field(32'(kept_after2));
		cand[2].last_result   = 1'b1;

		cand_valid = {end_of_buffer, keep2, keep1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			zero_phase_q    <= anbs_pkg::ZP_NONE;
			start_pending_q <= 1'b0;
			unit_open_q     <= 1'b0;
			open_offset_q   <= '0;
			open_type_q     <= '0;
			kept_total_q    <= '0;
		end else if (advance) begin
			if (end_of_buffer) begin
				byte_position_q <= '0;
				zero_phase_q    <= anbs_pkg::ZP_NONE;
				start_pending_q <= 1'b0;
				unit_open_q     <= 1'b0;
				open_offset_q   <= '0;
				open_type_q     <= '0;
				kept_total_q    <= '0;
			end else begin
				if (byte_position_q != POS_MAX) begin
					byte_position_q <= byte_position_q + 1'b1;
				end
				zero_phase_q    <= zero_phase_d;
				start_pending_q <= start_pending_d;
				unit_open_q     <= new_open;
				open_offset_q   <= new_offset;
				open_type_q     <= new_type;
				kept_total_q    <= kept_after1;
			end
		end
	end

endmodule

>>> src/anbs_rq.sv
// result queue, takes up to three records per cycle and hands out one per transfer
module anbs_rq (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            push,
	input  anbs_pkg::result_t [anbs_pkg::RESULT_SLOTS-1:0]  cand,
	input  logic [anbs_pkg::RESULT_SLOTS-1:0]               cand_valid,
	output logic                                            space,
	output logic                                            result_valid,
	input  logic                                            result_ready,
	output anbs_pkg::result_t                               head
);

	localparam int DEPTH = anbs_pkg::RQ_DEPTH;
	localparam int SLOTS = anbs_pkg::RESULT_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	anbs_pkg::result_t entry_q [DEPTH];
	logic [AW-1:0]     wptr_q;
	logic [AW-1:0]     rptr_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     wr_idx [SLOTS];
	logic [CW-1:0]     push_cnt;
	logic              pop;

	always_comb begin
		push_cnt = '0;
		for (int k = 0; k < SLOTS; k++) begin
			wr_idx[k] = wptr_q + AW'(push_cnt);
			if (cand_valid[k]) begin
				push_cnt = push_cnt + 1'b1;
			end
		end
	end

	assign pop          = result_valid && result_ready;
	assign result_valid = (count_q != '0);
	assign space        = (count_q <= CW'(DEPTH - SLOTS));
	assign head         = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			for (int k = 0; k < SLOTS; k++) begin
				if (cand_valid[k]) begin
					entry_q[wr_idx[k]] <= cand[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + AW'(push_cnt);
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (push ? push_cnt : CW'(0)) - CW'(pop);
		end
	end

endmodule

>>> src/annexb_nal_unit_splitter_core.sv
// top level of the annex b nal unit splitter with register port and result queue
// Takes one byte of an H.264 Annex B buffer per clock while the result queue has room,
// and reports each kept NAL unit (offset, length, type, header length) followed by a
// summary record on the last byte. A byte passes an input register, is scanned
// against the running start-code state, and its records land in a four-entry result
// queue; a record can be taken once its byte has left the input register and the
// record is in the queue. A byte is held in the input register while the queue has
// fewer than three free entries, so with results taken every cycle the last byte of a
// buffer, which adds one to three records, can hold up intake. The user must write
// slice_header_limit (address 0) only while the block is idle, which is not enforced.
module annexb_nal_unit_splitter_core #(
	parameter int POSITION_BITS = anbs_pkg::POSITION_BITS_DEFAULT,
	parameter int COUNT_BITS    = anbs_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [anbs_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic [7:0]                          data_byte,
	input  logic                                end_of_buffer,
	input  logic                                byte_valid,
	output logic                                byte_ready,
	output logic                                record_kind,
	output logic [anbs_pkg::OFFSET_W-1:0]       unit_offset,
	output logic [anbs_pkg::OFFSET_W-1:0]       unit_length,
	output logic [anbs_pkg::OFFSET_W-1:0]       header_length,
	output logic [anbs_pkg::TYPE_W-1:0]         unit_type,
	output logic [anbs_pkg::COUNT_W-1:0]        kept_count,
	output logic                                last_result,
	output logic                                result_valid,
	input  logic                                result_ready
);

	logic                                              valid_s1;
	logic [7:0]                                        data_byte_s1;
	logic                                              end_of_buffer_s1;
	logic [15:0]                                       slice_header_limit_q;
	logic                                              reg_hit;
	logic                                              advance;
	logic                                              rq_space;
	anbs_pkg::result_t [anbs_pkg::RESULT_SLOTS-1:0]    cand;
	logic [anbs_pkg::RESULT_SLOTS-1:0]                 cand_valid;
	anbs_pkg::result_t                                 head;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[anbs_pkg::ADDR_BITS-1:2] == anbs_pkg::REG_SLICE_HEADER_LIMIT);
	assign prdata  = reg_hit ? {16'b0, slice_header_limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_header_limit_q <= anbs_pkg::SLICE_HEADER_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			slice_header_limit_q <= pwdata[15:0];
		end
	end

	assign advance    = valid_s1 && rq_space;
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_byte_s1     <= data_byte;
			end_of_buffer_s1 <= end_of_buffer;
		end
	end

	anbs_parse #(
		.POSITION_BITS (POSITION_BITS),
		.COUNT_BITS    (COUNT_BITS)
	) u_parse (
		.clk                (clk),
		.arst_n             (arst_n),
		.advance            (advance),
		.data_byte          (data_byte_s1),
		.end_of_buffer      (end_of_buffer_s1),
		.slice_header_limit (slice_header_limit_q),
		.cand               (cand),
		.cand_valid         (cand_valid)
	);

	anbs_rq u_rq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (advance),
		.cand         (cand),
		.cand_valid   (cand_valid),
		.space        (rq_space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.head         (head)
	);

	assign record_kind   = head.record_kind;
	assign unit_offset   = head.unit_offset;
	assign unit_length   = head.unit_length;
	assign header_length = head.header_length;
	assign unit_type     = head.unit_type;
	assign kept_count    = head.kept_count;
	assign last_result   = head.last_result;

	a_summary_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && record_kind == anbs_pkg::KIND_SUMMARY |-> last_result)
		else $error("summary record without last_result");

	a_unit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && record_kind == anbs_pkg::KIND_UNIT
		|-> kept_count == '0 && header_length <= unit_length)
		else $error("unit record fields out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_byte_s1)
		&& $stable(end_of_buffer_s1))
		else $error("stalled input byte lost");

endmodule

>>> verif/tb_annexb_nal_unit_splitter_core.sv
// testbench for the annex b nal unit splitter core: directed and random buffers
`timescale 1ns / 100ps

module tb_annexb_nal_unit_splitter_core;

	localparam int RESET_CYCLES  = 12;
	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 4000;
	localparam logic [31:0] POS_MAX  = (32'd1 << anbs_pkg::POSITION_BITS_DEFAULT) - 32'd1;
	localparam logic [15:0] KEPT_MAX = 16'hFFFF;
	localparam logic [anbs_pkg::ADDR_BITS-1:0] LIMIT_ADDR =
		{anbs_pkg::REG_SLICE_HEADER_LIMIT, 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [anbs_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic [7:0] data_byte = '0;
	logic end_of_buffer = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	logic record_kind;
	logic [anbs_pkg::OFFSET_W-1:0] unit_offset;
	logic [anbs_pkg::OFFSET_W-1:0] unit_length;
	logic [anbs_pkg::OFFSET_W-1:0] header_length;
	logic [anbs_pkg::TYPE_W-1:0] unit_type;
	logic [anbs_pkg::COUNT_W-1:0] kept_count;
	logic last_result;
	logic result_valid;
	logic result_ready = 1'b0;

	// predictor state
	logic [15:0] cfg_slice_limit = anbs_pkg::SLICE_HEADER_LIMIT_RESET;
	logic [31:0] scan_pos = '0;
	anbs_pkg::zphase_t zero_run = anbs_pkg::ZP_NONE;
	logic header_next = 1'b0;
	logic unit_is_open = 1'b0;
	logic [31:0] unit_start = '0;
	logic [anbs_pkg::TYPE_W-1:0] unit_nal_type = '0;
	logic [15:0] units_kept = '0;
	anbs_pkg::result_t step_out[anbs_pkg::RESULT_SLOTS];
	int step_n;

	anbs_pkg::result_t records_due[$];
	anbs_pkg::result_t want_rec;
	logic [7:0] stream_bytes[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_request = 1'b0;
	int fail_count = 0;
	int bytes_sent = 0;
	int buffers_sent = 0;
	int records_checked = 0;
	int quiet_cycles = 0;

	annexb_nal_unit_splitter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.record_kind(record_kind),
		.unit_offset(unit_offset),
		.unit_length(unit_length),
		.header_length(header_length),
		.unit_type(unit_type),
		.kept_count(kept_count),
		.last_result(last_result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	always #1 clk = ~clk;

	task automatic close_open_unit(input logic [31:0] len);
		logic [31:0] hdr;
		logic keep;
		anbs_pkg::result_t rec;
		unit_is_open = 1'b0;
		keep = 1'b1;
		hdr = len;
		if (unit_nal_type >= anbs_pkg::SLICE_TYPE_MIN
				&& unit_nal_type <= anbs_pkg::SLICE_TYPE_MAX) begin
			if (len > {16'd0, cfg_slice_limit})
				hdr = {16'd0, cfg_slice_limit};
		end else if (!(unit_nal_type >= anbs_pkg::WHOLE_TYPE_MIN
				&& unit_nal_type <= anbs_pkg::WHOLE_TYPE_MAX)) begin
			keep = 1'b0;
		end
		if (keep) begin
			if (units_kept != KEPT_MAX)
				units_kept++;
			rec = '0;
			rec.record_kind = anbs_pkg::KIND_UNIT;
			rec.unit_offset = unit_start[anbs_pkg::OFFSET_W-1:0];
			rec.unit_length = len[anbs_pkg::OFFSET_W-1:0];
			rec.header_length = hdr[anbs_pkg::OFFSET_W-1:0];
			rec.unit_type = unit_nal_type;
			step_out[step_n] = rec;
			step_n++;
		end
	endtask

	task automatic predict_byte(input logic [7:0] value, input logic last);
		logic [31:0] pos;
		logic [31:0] span;
		logic [31:0] stop;
		anbs_pkg::result_t rec;
		pos = scan_pos;
		step_n = 0;
		if (header_next) begin
			// header byte of a new unit is not scanned
			header_next = 1'b0;
			zero_run = anbs_pkg::ZP_NONE;
			if (unit_is_open) begin
				span = pos - unit_start;
				close_open_unit((pos >= unit_start && span >= anbs_pkg::PREFIX_LEN) ?
					span - anbs_pkg::PREFIX_LEN : 32'd0);
			end
			unit_is_open = 1'b1;
			unit_start = pos;
			unit_nal_type = value[anbs_pkg::TYPE_W-1:0];
		end else if (value == anbs_pkg::BYTE_ZERO) begin
			zero_run = (zero_run == anbs_pkg::ZP_NONE) ? anbs_pkg::ZP_ONE : anbs_pkg::ZP_MANY;
		end else if (value == anbs_pkg::BYTE_ONE && zero_run == anbs_pkg::ZP_MANY) begin
			zero_run = anbs_pkg::ZP_NONE;
			header_next = 1'b1;
		end else begin
			zero_run = anbs_pkg::ZP_NONE;
		end
		if (last) begin
			stop = (pos < POS_MAX) ? pos + 32'd1 : POS_MAX;
			if (unit_is_open)
				close_open_unit((stop >= unit_start) ? stop - unit_start : 32'd0);
			rec = '0;
			rec.record_kind = anbs_pkg::KIND_SUMMARY;
			rec.kept_count = units_kept;
			step_out[step_n] = rec;
			step_n++;
			scan_pos = '0;
			zero_run = anbs_pkg::ZP_NONE;
			header_next = 1'b0;
			unit_is_open = 1'b0;
			unit_start = '0;
			unit_nal_type = '0;
			units_kept = '0;
		end else if (scan_pos < POS_MAX) begin
			scan_pos++;
		end
		for (int i = 0; i < step_n; i++) begin
			rec = step_out[i];
			rec.last_result = (i == step_n - 1);
			records_due.push_back(rec);
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	// receiver: random ready, or a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (records_due.size() == 0) begin
				$error("result transfer with no record outstanding");
				fail_count++;
			end else begin
				want_rec = records_due.pop_front();
				check_field("record_kind", want_rec.record_kind, record_kind);
				check_field("unit_offset", want_rec.unit_offset, unit_offset);
				check_field("unit_length", want_rec.unit_length, unit_length);
				check_field("header_length", want_rec.header_length, header_length);
				check_field("unit_type", want_rec.unit_type, unit_type);
				check_field("kept_count", want_rec.kept_count, kept_count);
				check_field("last_result", want_rec.last_result, last_result);
				records_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no transfer for %0d cycles", STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= value;
		end_of_buffer <= last;
		do @(posedge clk); while (!byte_ready);
		predict_byte(value, last);
		bytes_sent++;
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_bytes.size(); i++)
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		buffers_sent++;
	endtask

	task automatic drain_records();
		byte_valid <= 1'b0;
		while (records_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slice_limit(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cfg_slice_limit = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("slice_header_limit", value, prdata[15:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] payload_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			return anbs_pkg::BYTE_ZERO;
		else if (pick < 35)
			return anbs_pkg::BYTE_ONE;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] header_byte();
		logic [7:0] h;
		h = 8'($urandom);
		if ($urandom_range(99) < 70)
			h[anbs_pkg::TYPE_W-1:0] = 5'($urandom_range(1, 8));
		return h;
	endfunction

	// start-code framed units; broken ones get short zero runs or a missing header
	task automatic build_stream(input int units, input bit broken);
		int n;
		stream_bytes.delete();
		repeat ($urandom_range(0, 2)) stream_bytes.push_back(payload_byte());
		repeat (units) begin
			n = $urandom_range(2, 4);
			if (broken && $urandom_range(3) == 0)
				n = 1;
			repeat (n) stream_bytes.push_back(anbs_pkg::BYTE_ZERO);
			stream_bytes.push_back(anbs_pkg::BYTE_ONE);
			if (!(broken && $urandom_range(7) == 0))
				stream_bytes.push_back(header_byte());
			repeat ($urandom_range(0, 8)) stream_bytes.push_back(payload_byte());
		end
		if (stream_bytes.size() == 0)
			stream_bytes.push_back(payload_byte());
	endtask

	task automatic build_noise(input int len);
		stream_bytes.delete();
		repeat (len) stream_bytes.push_back(payload_byte());
	endtask

	task automatic test_directed_cases();
		tx_idle_pct = 12;
		rx_idle_pct = 88;
		// single byte, no unit
		stream_bytes = '{8'hFF};
		send_stream();
		// start code completed by the last byte
		stream_bytes = '{8'h00, 8'h00, 8'h01};
		send_stream();
		// long zero run, unscanned header byte, three records on the last byte
		stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h01, 8'hE6, 8'h00, 8'h00, 8'h01, 8'hE6,
			8'h00, 8'h00, 8'h01, 8'hE8};
		send_stream();
		drain_records();
	endtask

	task automatic test_slice_limits();
		logic [15:0] limits[4];
		limits = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 6))};
		tx_idle_pct = 12;
		rx_idle_pct = 88;
		foreach (limits[i]) begin
			drain_records();
			write_slice_limit(limits[i]);
			build_stream(2, 1'b0);
			send_stream();
		end
		drain_records();
	endtask

	task automatic test_receiver_hold();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		drain_records();
		write_slice_limit(anbs_pkg::SLICE_HEADER_LIMIT_RESET);
		stream_bytes.delete();
		repeat (8) begin
			stream_bytes.push_back(anbs_pkg::BYTE_ZERO);
			stream_bytes.push_back(anbs_pkg::BYTE_ZERO);
			stream_bytes.push_back(anbs_pkg::BYTE_ONE);
			stream_bytes.push_back({3'($urandom), 5'($urandom_range(1, 8))});
		end
		hold_request = 1'b1;
		send_stream();
		drain_records();
	endtask

	task automatic test_random_streams(input int tx_pct, input int rx_pct, input int target);
		int first;
		int pick;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		first = bytes_sent;
		while (bytes_sent - first < target) begin
			pick = $urandom_range(9);
			if (pick == 0)
				build_noise($urandom_range(1, 12));
			else
				build_stream($urandom_range(0, 4), pick == 1);
			send_stream();
			if ($urandom_range(3) == 0) begin
				drain_records();
				write_slice_limit(16'($urandom_range(0, 12)));
			end
		end
		drain_records();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_slice_limits();
		test_random_streams(88, 12, 70);
		test_receiver_hold();
		test_random_streams(0, 0, 70);
		$display("sent %0d bytes in %0d buffers, checked %0d records", bytes_sent, buffers_sent,
			records_checked);
		$display("covered slice limits 0, 1, 256, 65535 and small values, plus a long output stall");
		if (fail_count == 0 && records_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
src/anbs_pkg.sv
src/anbs_parse.sv
src/anbs_rq.sv
src/annexb_nal_unit_splitter_core.sv
verif/tb_annexb_nal_unit_splitter_core.sv
